// ----- sv/tfd_pkg.sv -----
// Package for the telemetry frame decoder: header and type characters,
// frame kinds, parser states, decode operations and the record types.
// No dependencies.
package tfd_pkg;

  // Payload store depth by default (longest payload is 14 bytes)
  localparam int MAX_PAYLOAD_DEF = 14;
  // Frames held between parser and decoder
  localparam int QUEUE_DEPTH = 2;

  // Header and type characters
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_O      = 8'h4F;
  localparam logic [7:0] CHAR_N      = 8'h4E;
  localparam logic [7:0] CHAR_X      = 8'h58;

  // Reciprocal constants: x/10 for x < 16384, x/100 for any 32-bit x
  localparam logic [31:0] DIV10_MUL  = 32'd6554;
  localparam logic [31:0] DIV100_MUL = 32'h51EB851F;
  localparam logic [15:0] HEADING_WRAP = 16'd360;

  typedef enum logic [2:0] {
    KIND_POS   = 3'd0,
    KIND_ATT   = 3'd1,
    KIND_SENS  = 3'd2,
    KIND_ORIG  = 3'd3,
    KIND_NAV   = 3'd4,
    KIND_EXTRA = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_DOLLAR,
    PS_HDR,
    PS_DATA
  } parse_state_t;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_KMH,
    OP_ALT
  } dec_op_t;

  // One finished frame as handed from parser to decoder
  typedef struct packed {
    kind_t       kind;
    logic        bad;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
  } frame_rec_t;

  // Side fields of one result as it moves down the decode pipeline
  typedef struct packed {
    kind_t       kind;
    logic        status;
    logic [2:0]  value_id;
    logic        last;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
  } res_meta_t;

  // Payload length of each frame kind
  function automatic logic [3:0] payload_len(input kind_t kind);
    logic [3:0] len;
    unique case (kind)
      KIND_POS:  len = 4'd14;
      KIND_ATT:  len = 4'd6;
      KIND_SENS: len = 4'd7;
      KIND_ORIG: len = 4'd14;
      default:   len = 4'd6;
    endcase
    return len;
  endfunction

  // Number of decoded values of each frame kind
  function automatic logic [2:0] value_count(input kind_t kind);
    logic [2:0] cnt;
    unique case (kind)
      KIND_POS:  cnt = 3'd7;
      KIND_ATT:  cnt = 3'd3;
      KIND_SENS: cnt = 3'd7;
      KIND_ORIG: cnt = 3'd5;
      KIND_NAV:  cnt = 3'd6;
      default:   cnt = 3'd5;
    endcase
    return cnt;
  endfunction

endpackage

// ----- sv/telemetry_frame_decoder.sv -----
// Telemetry frame decoder top level: parser, frame queue, value decoder.
// Takes one byte per cycle; a frame queue of two entries separates parsing from decoding.
// Frame results pass the select, multiply and output registers once the checksum is taken.
// Throughput: one byte per cycle in, one result per cycle out while m_tready is high; input
// stalls only on a full queue. Reset (rst, synchronous) clears parser, counters, queue.
module telemetry_frame_decoder import tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] value, [63:32] good_frames, [95:64] bad_frames
  output logic [6:0]  m_tuser,   // [2:0] frame_kind, [3] status, [6:4] value_id
  output logic        m_tlast
);

  localparam int PAY_W = MAX_PAYLOAD * 8;
  localparam int Q_W   = $bits(frame_rec_t) + PAY_W;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  frame_rec_t       push_rec;
  logic [PAY_W-1:0] push_payload;
  logic [Q_W-1:0]   head;
  frame_rec_t       head_rec;
  res_meta_t        out_meta;
  logic [31:0]      out_value;

  tfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (push_rec),
    .q_payload (push_payload)
  );

  tfd_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({push_rec, push_payload}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head),
    .empty (q_empty)
  );

  assign head_rec = head[Q_W-1:PAY_W];

  tfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rec     (head_rec),
    .q_payload (head[PAY_W-1:0]),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_meta  (out_meta),
    .out_value (out_value)
  );

  // Pack the result
  assign m_tdata = {out_meta.bad_cnt, out_meta.good_cnt, out_value};
  assign m_tuser = {out_meta.value_id, out_meta.status, out_meta.kind};
  assign m_tlast = out_meta.last;

  // Parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("frame pushed into full queue");

  // Decoder never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("frame popped from empty queue");

  // A dropped frame gives a single zero-valued result
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> (m_tlast && (m_tuser[6:4] == 3'd0) &&
                                  (m_tdata[31:0] == 32'd0)))
    else $error("dropped frame result malformed");

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

// ----- sv/tfd_front.sv -----
// Frame parser: hunts for the header, buffers the payload, checks the XOR, counts good and bad
// frames, and pushes one record per finished frame.
// Depends on tfd_pkg.
module tfd_front import tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     q_full,
  output logic                     q_push,
  output frame_rec_t               q_rec,
  output logic [MAX_PAYLOAD*8-1:0] q_payload
);

  localparam int IDX_W = $clog2(MAX_PAYLOAD);

  parse_state_t state, state_next;
  kind_t        frame_type;
  logic [3:0]   payload_index;
  logic [7:0]   running_xor;
  logic [7:0]   payload [MAX_PAYLOAD];
  logic [31:0]  good_count;
  logic [31:0]  bad_count;

  logic         accept;
  logic         type_hit;
  kind_t        type_kind;
  logic [7:0]   xor_val;
  logic         frame_end;
  logic         frame_bad;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the type byte
  always_comb begin
    type_hit  = 1'b1;
    type_kind = KIND_POS;
    unique case (in_byte)
      CHAR_G:  type_kind = KIND_POS;
      CHAR_A:  type_kind = KIND_ATT;
      CHAR_S:  type_kind = KIND_SENS;
      CHAR_O:  type_kind = KIND_ORIG;
      CHAR_N:  type_kind = KIND_NAV;
      CHAR_X:  type_kind = KIND_EXTRA;
      default: type_hit = 1'b0;
    endcase
  end

  assign xor_val   = (payload_index == 4'd0) ? in_byte : (running_xor ^ in_byte);
  assign frame_end = (state == PS_DATA) && (payload_index >= payload_len(frame_type));
  assign frame_bad = (xor_val != 8'd0);

  // Next parser state
  always_comb begin
    state_next = state;
    unique case (state)
      PS_IDLE:   state_next = (in_byte == CHAR_DOLLAR) ? PS_DOLLAR : PS_IDLE;
      PS_DOLLAR: state_next = (in_byte == CHAR_T) ? PS_HDR : PS_IDLE;
      PS_HDR:    state_next = type_hit ? PS_DATA : PS_IDLE;
      PS_DATA:   state_next = frame_end ? PS_IDLE : PS_DATA;
      default:   state_next = PS_IDLE;
    endcase
  end

  // Push a record on the checksum byte
  always_comb begin
    q_push         = accept && frame_end;
    q_rec.kind     = frame_type;
    q_rec.bad      = frame_bad;
    q_rec.good_cnt = good_count + {31'd0, !frame_bad};
    q_rec.bad_cnt  = bad_count + {31'd0, frame_bad};
  end

  always_comb begin
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      q_payload[i*8 +: 8] = payload[i];
    end
  end

  // Parser control state and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= PS_IDLE;
      frame_type    <= KIND_POS;
      payload_index <= 4'd0;
      running_xor   <= 8'd0;
      good_count    <= 32'd0;
      bad_count     <= 32'd0;
    end else if (accept) begin
      state <= state_next;
      if (state == PS_HDR) begin
        payload_index <= 4'd0;
        if (type_hit) begin
          frame_type <= type_kind;
        end
      end
      if (state == PS_DATA) begin
        running_xor <= xor_val;
        if (!frame_end) begin
          payload_index <= payload_index + 4'd1;
        end else begin
          good_count <= q_rec.good_cnt;
          bad_count  <= q_rec.bad_cnt;
        end
      end
    end
  end

  // Store payload bytes
  always_ff @(posedge clk) begin
    if (accept && (state == PS_DATA) && !frame_end &&
        ({1'b0, payload_index} < 5'(MAX_PAYLOAD))) begin
      payload[payload_index[IDX_W-1:0]] <= in_byte;
    end
  end

endmodule

// ----- sv/tfd_queue.sv -----
// Short frame queue between parser and decoder, register based.
// Depends on tfd_pkg for the default depth.
module tfd_queue import tfd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Write entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ----- sv/tfd_back.sv -----
// Value decoder: walks the values of the frame at the head of the queue,
// three stages (select, multiply, finish) into the output register.
// Depends on tfd_pkg.
module tfd_back import tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  frame_rec_t               q_rec,
  input  logic [MAX_PAYLOAD*8-1:0] q_payload,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output res_meta_t                out_meta,
  output logic [31:0]              out_value
);

  logic        adv;
  logic        take;
  logic [2:0]  k;
  logic [2:0]  n_vals;
  logic        is_last;
  logic [7:0]  pb [14];

  // Select stage results
  dec_op_t     sel_op;
  logic [31:0] sel_opnd;
  logic        sel_neg;
  logic [31:0] alt_raw;
  logic [31:0] alt_mag;
  logic [15:0] head_raw;
  logic [15:0] head_adj;
  logic [13:0] kmh_x;
  logic [14:0] rssi_x;
  logic [15:0] rssi_sum;
  logic [15:0] air_x;

  // Pipeline registers
  logic        s1_valid;
  res_meta_t   s1_meta;
  dec_op_t     s1_op;
  logic [31:0] s1_opnd;
  logic        s1_neg;
  logic        s2_valid;
  res_meta_t   s2_meta;
  dec_op_t     s2_op;
  logic [31:0] s2_opnd;
  logic        s2_neg;
  logic [63:0] s2_prod;

  logic [31:0] mul_c;
  logic [63:0] prod_c;
  logic [31:0] quot_c;
  logic [31:0] fin_value;

  // The whole pipeline moves when the output slot is free
  assign adv     = !out_valid || out_ready;
  assign take    = adv && !q_empty;
  assign n_vals  = q_rec.bad ? 3'd1 : value_count(q_rec.kind);
  assign is_last = (k == n_vals - 3'd1);
  assign q_pop   = take && is_last;

  always_comb begin
    for (int i = 0; i < 14; i++) begin
      pb[i] = q_payload[i*8 +: 8];
    end
  end

  // Operands of the converted fields
  always_comb begin
    alt_raw  = {pb[12], pb[11], pb[10], pb[9]};
    alt_mag  = alt_raw[31] ? (32'd0 - alt_raw) : alt_raw;
    head_raw = {pb[5], pb[4]};
    head_adj = head_raw[15] ? (head_raw + HEADING_WRAP) : head_raw;
    kmh_x    = ({6'd0, pb[8]} * 14'd36) + 14'd5;
    rssi_x   = {7'd0, pb[4]} * 15'd100;
    rssi_sum = {1'b0, rssi_x} + {9'd0, rssi_x[14:8]} + 16'd1;
    air_x    = {8'd0, pb[5]} * 16'd100;
  end

  // Select the value for index k of the head frame
  always_comb begin
    sel_op   = OP_PASS;
    sel_opnd = 32'd0;
    sel_neg  = 1'b0;
    if (!q_rec.bad) begin
      unique case (q_rec.kind)
        KIND_POS: begin
          case (k)
            3'd0: sel_opnd = {pb[3], pb[2], pb[1], pb[0]};
            3'd1: sel_opnd = {pb[7], pb[6], pb[5], pb[4]};
            3'd2: sel_opnd = {24'd0, pb[8]};
            3'd3: begin
              sel_op   = OP_KMH;
              sel_opnd = {18'd0, kmh_x};
            end
            3'd4: begin
              sel_op   = OP_ALT;
              sel_opnd = alt_mag;
              sel_neg  = alt_raw[31];
            end
            3'd5: sel_opnd = {26'd0, pb[13][7:2]};
            default: sel_opnd = {30'd0, pb[13][1:0]};
          endcase
        end
        KIND_ATT: begin
          case (k)
            3'd0: sel_opnd = {{16{pb[1][7]}}, pb[1], pb[0]};
            3'd1: sel_opnd = {{16{pb[3][7]}}, pb[3], pb[2]};
            default: sel_opnd = {{16{head_adj[15]}}, head_adj};
          endcase
        end
        KIND_SENS: begin
          case (k)
            3'd0: sel_opnd = {16'd0, pb[1], pb[0]};
            3'd1: sel_opnd = {16'd0, pb[3], pb[2]};
            3'd2: sel_opnd = {24'd0, rssi_sum[15:8]};
            3'd3: sel_opnd = {24'd0, air_x[7:0]};
            3'd4: sel_opnd = {31'd0, pb[6][0]};
            3'd5: sel_opnd = {31'd0, pb[6][1]};
            default: sel_opnd = {26'd0, pb[6][7:2]};
          endcase
        end
        KIND_ORIG: begin
          case (k)
            3'd0: sel_opnd = {pb[3], pb[2], pb[1], pb[0]};
            3'd1: sel_opnd = {pb[7], pb[6], pb[5], pb[4]};
            3'd2: sel_opnd = {pb[11], pb[10], pb[9], pb[8]};
            3'd3: sel_opnd = {24'd0, pb[12]};
            default: sel_opnd = {24'd0, pb[13]};
          endcase
        end
        KIND_NAV: begin
          case (k)
            3'd0: sel_opnd = {24'd0, pb[0]};
            3'd1: sel_opnd = {24'd0, pb[1]};
            3'd2: sel_opnd = {24'd0, pb[2]};
            3'd3: sel_opnd = {24'd0, pb[3]};
            3'd4: sel_opnd = {24'd0, pb[4]};
            default: sel_opnd = {24'd0, pb[5]};
          endcase
        end
        default: begin
          case (k)
            3'd0: sel_opnd = {16'd0, pb[1], pb[0]};
            3'd1: sel_opnd = {24'd0, pb[2]};
            3'd2: sel_opnd = {24'd0, pb[3]};
            3'd3: sel_opnd = {24'd0, pb[4]};
            default: sel_opnd = {24'd0, pb[5]};
          endcase
        end
      endcase
    end
  end

  // Reciprocal multiply for the divided fields
  assign mul_c  = (s1_op == OP_ALT) ? DIV100_MUL : DIV10_MUL;
  assign prod_c = 64'(s1_opnd) * 64'(mul_c);

  // Finish: shift the product, restore the sign
  always_comb begin
    quot_c = 32'd0;
    case (s2_op)
      OP_ALT: begin
        quot_c    = {5'd0, s2_prod[63:37]};
        fin_value = s2_neg ? (32'd0 - quot_c) : quot_c;
      end
      OP_KMH:  fin_value = {16'd0, s2_prod[31:16]};
      default: fin_value = s2_opnd;
    endcase
  end

  // Valid bits and value counter
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= 3'd0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      if (take) begin
        k <= is_last ? 3'd0 : k + 3'd1;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta.kind     <= q_rec.kind;
      s1_meta.status   <= q_rec.bad;
      s1_meta.value_id <= k;
      s1_meta.last     <= is_last;
      s1_meta.good_cnt <= q_rec.good_cnt;
      s1_meta.bad_cnt  <= q_rec.bad_cnt;
      s1_op            <= sel_op;
      s1_opnd          <= sel_opnd;
      s1_neg           <= sel_neg;
      s2_meta          <= s1_meta;
      s2_op            <= s1_op;
      s2_opnd          <= s1_opnd;
      s2_neg           <= s1_neg;
      s2_prod          <= prod_c;
      out_meta         <= s2_meta;
      out_value        <= fin_value;
    end
  end

endmodule
